// ===== hdl/assert_macros.svh =====
// Assertion helpers for the step controller checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define CHK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/ntsc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntsc_pkg
// Types and constants shared by the Newton time-step controller modules.
// ----------------------------------------------------------------------------
package ntsc_pkg;

  localparam int STEP_W   = 32;  // Q16.16 step size
  localparam int FAC_W    = 16;  // Q2.14 factor
  localparam int FRAC_FAC = 14;  // fraction bits of a factor
  localparam int CNT_W    = 8;   // streak counters and iteration counts
  localparam int PROD_W   = STEP_W + FAC_W;
  localparam int SCL_W    = PROD_W - FRAC_FAC;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // Register reset values
  localparam logic [31:0] GROWTH_RST  = 32'h8000_6000;
  localparam logic [15:0] SHRINK_RST  = 16'h3333;
  localparam logic [47:0] RETRY_RST   = 48'h00A4_0666_2000;
  localparam logic [23:0] THRESH_RST  = 24'h0A_0306;
  localparam logic [23:0] LIMITS_RST  = 24'h04_0300;
  localparam logic [31:0] MAX_STEP_RST = 32'hFFFF_FFFF;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GROWTH   = 3'd0,
    REG_SHRINK   = 3'd1,
    REG_RETRY    = 3'd2,
    REG_THRESH   = 3'd3,
    REG_LIMITS   = 3'd4,
    REG_MAX_STEP = 3'd5
  } cfg_idx_t;

  // Input item
  typedef struct packed {
    logic [STEP_W-1:0] step_size;
    logic              converged;
    logic [CNT_W-1:0]  iterations;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic [STEP_W-1:0] new_step;
    logic              stop;
    logic              reset_jacobian;
  } out_item_t;

  // Configuration register contents
  typedef struct packed {
    logic [31:0] growth_factors;
    logic [15:0] shrink_factor;
    logic [47:0] retry_factors;
    logic [23:0] iteration_thresholds;
    logic [23:0] streak_limits;
    logic [31:0] max_step;
  } cfg_t;

  // Decision handed from the decide stage to the scale stage
  typedef struct packed {
    logic [STEP_W-1:0] step;
    logic [FAC_W-1:0]  factor;
    logic              scale_en;
    logic              stop;
    logic              rst_jac;
  } dec_t;

  // Saturating counter increment
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

// ===== hdl/ntsc_cfg.sv =====
// ----------------------------------------------------------------------------
// ntsc_cfg
// Configuration register file, written through a valid/ready port.
// ----------------------------------------------------------------------------
module ntsc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ntsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ntsc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output ntsc_pkg::cfg_t                    cfg
);

  ntsc_pkg::cfg_t cfg_r;

  // Writes are always taken
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  // Register write, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.growth_factors       <= ntsc_pkg::GROWTH_RST;
      cfg_r.shrink_factor        <= ntsc_pkg::SHRINK_RST;
      cfg_r.retry_factors        <= ntsc_pkg::RETRY_RST;
      cfg_r.iteration_thresholds <= ntsc_pkg::THRESH_RST;
      cfg_r.streak_limits        <= ntsc_pkg::LIMITS_RST;
      cfg_r.max_step             <= ntsc_pkg::MAX_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (ntsc_pkg::cfg_idx_t'(cfg_index))
        ntsc_pkg::REG_GROWTH:   cfg_r.growth_factors       <= cfg_data[31:0];
        ntsc_pkg::REG_SHRINK:   cfg_r.shrink_factor        <= cfg_data[15:0];
        ntsc_pkg::REG_RETRY:    cfg_r.retry_factors        <= cfg_data[47:0];
        ntsc_pkg::REG_THRESH:   cfg_r.iteration_thresholds <= cfg_data[23:0];
        ntsc_pkg::REG_LIMITS:   cfg_r.streak_limits        <= cfg_data[23:0];
        ntsc_pkg::REG_MAX_STEP: cfg_r.max_step             <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hdl/ntsc_decide.sv =====
// ----------------------------------------------------------------------------
// ntsc_decide
// Input register, streak state and factor selection for each item.
// ----------------------------------------------------------------------------
module ntsc_decide (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ntsc_pkg::cfg_t       cfg,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ntsc_pkg::in_item_t   in_data,
  output logic                 dec_valid,
  input  logic                 dec_stall,
  output ntsc_pkg::dec_t       dec
);

  localparam int CW = ntsc_pkg::CNT_W;

  ntsc_pkg::in_item_t in_r;
  logic               in_vld_r;
  ntsc_pkg::dec_t     dec_r, dec_nxt;
  logic               dec_vld_r;

  logic [CW-1:0] succ_r, succ_nxt;
  logic [CW-1:0] fail1_r, fail1_nxt;
  logic [CW-1:0] fail2_r, fail2_nxt;
  logic          last_used_r, last_used_nxt;
  logic          started_r;

  logic          dec_ready, in_ready, proc;
  logic [CW-1:0] need, lim1, lim2, grow_below, big_below, shrink_above;
  logic [CW-1:0] succ_base, succ_inc, f1_inc, f2_inc;

  // Handshake: stall ripples back from the scale stage
  assign dec_ready = !dec_vld_r || !dec_stall;
  assign in_ready  = !in_vld_r || dec_ready;
  assign in_stall  = !in_ready;
  assign proc      = in_vld_r && dec_ready;
  assign dec_valid = dec_vld_r;
  assign dec       = dec_r;

  // Register fields
  assign need         = cfg.streak_limits[7:0];
  assign lim1         = cfg.streak_limits[15:8];
  assign lim2         = cfg.streak_limits[23:16];
  assign grow_below   = cfg.iteration_thresholds[7:0];
  assign big_below    = cfg.iteration_thresholds[15:8];
  assign shrink_above = cfg.iteration_thresholds[23:16];

  // First item preloads the success streak
  assign succ_base = started_r ? succ_r : need;
  assign succ_inc  = ntsc_pkg::sat_inc(succ_base);
  assign f1_inc    = ntsc_pkg::sat_inc(fail1_r);
  assign f2_inc    = ntsc_pkg::sat_inc(fail2_r);

  // Decision and next state
  always_comb begin
    dec_nxt.step     = in_r.step_size;
    dec_nxt.factor   = '0;
    dec_nxt.scale_en = 1'b0;
    dec_nxt.stop     = 1'b0;
    dec_nxt.rst_jac  = 1'b0;
    succ_nxt         = succ_base;
    fail1_nxt        = fail1_r;
    fail2_nxt        = fail2_r;
    last_used_nxt    = last_used_r;
    if (in_r.converged) begin
      last_used_nxt = 1'b0;
      fail1_nxt     = '0;
      fail2_nxt     = '0;
      if (in_r.iterations < grow_below) begin
        succ_nxt = succ_inc;
        if (succ_inc >= need) begin
          dec_nxt.scale_en = 1'b1;
          dec_nxt.factor   = (in_r.iterations < big_below) ?
                             cfg.growth_factors[31:16] : cfg.growth_factors[15:0];
        end
      end
      // Too many iterations overrides growth
      if (in_r.iterations > shrink_above) begin
        succ_nxt         = '0;
        dec_nxt.rst_jac  = 1'b1;
        dec_nxt.scale_en = 1'b1;
        dec_nxt.factor   = cfg.shrink_factor;
      end
    end else begin
      succ_nxt         = '0;
      dec_nxt.rst_jac  = 1'b1;
      dec_nxt.scale_en = 1'b1;
      fail1_nxt        = f1_inc;
      if (f1_inc <= lim1) begin
        dec_nxt.factor = cfg.retry_factors[15:0];
      end else begin
        fail2_nxt = f2_inc;
        if (f2_inc <= lim2) begin
          dec_nxt.factor = cfg.retry_factors[31:16];
        end else if (!last_used_r) begin
          dec_nxt.factor = cfg.retry_factors[47:32];
          last_used_nxt  = 1'b1;
        end else begin
          // Final cut already failed: stop, streaks and flags hold
          dec_nxt.stop     = 1'b1;
          dec_nxt.rst_jac  = 1'b0;
          dec_nxt.scale_en = 1'b0;
          succ_nxt         = succ_base;
          fail1_nxt        = fail1_r;
          fail2_nxt        = fail2_r;
          last_used_nxt    = last_used_r;
        end
      end
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  // Streak state, updated as each item is decided
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      succ_r      <= '0;
      fail1_r     <= '0;
      fail2_r     <= '0;
      last_used_r <= 1'b0;
      started_r   <= 1'b0;
    end else if (proc) begin
      succ_r      <= succ_nxt;
      fail1_r     <= fail1_nxt;
      fail2_r     <= fail2_nxt;
      last_used_r <= last_used_nxt;
      started_r   <= 1'b1;
    end
  end

  // Decision register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dec_vld_r <= 1'b0;
    end else if (dec_ready) begin
      dec_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      dec_r <= dec_nxt;
    end
  end

endmodule

// ===== hdl/ntsc_scale.sv =====
// ----------------------------------------------------------------------------
// ntsc_scale
// Step scaling by a Q2.14 factor, clamp to max_step, and result register.
// ----------------------------------------------------------------------------
module ntsc_scale (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [ntsc_pkg::STEP_W-1:0]         max_step,
  input  logic                                dec_valid,
  output logic                                dec_stall,
  input  ntsc_pkg::dec_t                      dec,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ntsc_pkg::out_item_t                 out_data
);

  localparam int SW = ntsc_pkg::STEP_W;

  ntsc_pkg::out_item_t out_r, out_nxt;
  logic                out_vld_r;
  logic                out_ready;

  logic [ntsc_pkg::PROD_W-1:0] prod;
  logic [ntsc_pkg::SCL_W-1:0]  scaled, cand;

  assign out_ready = !out_vld_r || !out_stall;
  assign dec_stall = !out_ready;
  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // 32x16 product, truncated to Q18.16
  assign prod   = ntsc_pkg::PROD_W'(dec.step) * ntsc_pkg::PROD_W'(dec.factor);
  assign scaled = prod[ntsc_pkg::PROD_W-1:ntsc_pkg::FRAC_FAC];
  assign cand   = dec.scale_en ? scaled : ntsc_pkg::SCL_W'(dec.step);

  // Clamp; a stop result passes the step through
  always_comb begin
    out_nxt.stop           = dec.stop;
    out_nxt.reset_jacobian = dec.rst_jac;
    if (dec.stop) begin
      out_nxt.new_step = dec.step;
    end else if (cand > ntsc_pkg::SCL_W'(max_step)) begin
      out_nxt.new_step = max_step;
    end else begin
      out_nxt.new_step = cand[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_ready) begin
      out_vld_r <= dec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && dec_valid) begin
      out_r <= out_nxt;
    end
  end

endmodule

// ===== hdl/newton_time_step_controller.sv =====
// ----------------------------------------------------------------------------
// newton_time_step_controller
// Iteration-count adaptive time-step controller, one decision per cycle while out_stall is low.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  in_      in   in_valid/in_stall  in_item_t: step_size, converged, iterations
//  out_     out  out_valid/out_stall out_item_t: new_step, stop, reset_jacobian
//  cfg_     in   cfg_valid/cfg_ready cfg_index (3b), cfg_data (48b)
//
//  One item per cycle sustained while out_stall is low; each result passes
//  through three registers before it is presented (input register,
//  decision register, result register).
//  The streak state is updated in the decision stage, so consecutive items
//  see each other's effect with no bubble.
//  Synchronous active-low reset clears valids, streaks and configuration registers.
//  out_stall holds the result; once all three stages are full it reaches
//  in_stall in the same cycle.
// ----------------------------------------------------------------------------
module newton_time_step_controller (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ntsc_pkg::in_item_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ntsc_pkg::out_item_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ntsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ntsc_pkg::CFG_DATA_W-1:0]   cfg_data
);

  ntsc_pkg::cfg_t cfg;
  ntsc_pkg::dec_t dec;
  logic           dec_valid, dec_stall;

  // Configuration registers
  ntsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Streak tracking and factor choice
  ntsc_decide u_decide (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec       (dec)
  );

  // Multiply, clamp, result register
  ntsc_scale u_scale (
    .clk       (clk),
    .rst_n     (rst_n),
    .max_step  (cfg.max_step),
    .dec_valid (dec_valid),
    .dec_stall (dec_stall),
    .dec       (dec),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== hdl/ntsc_checker.sv =====
// ----------------------------------------------------------------------------
// ntsc_checker
// Port-level checks for the step controller, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ntsc_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input ntsc_pkg::out_item_t               out_data,
  input logic                              cfg_valid,
  input logic                              cfg_ready
);

  // A stalled result holds its transfer
  `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result not held")

  // Free output means the whole pipe can advance
  `CHK_SAME(a_flow, !out_stall, !in_stall, "input stalled with output free")

  // A stop never requests a Jacobian reset
  `CHK_SAME(a_stop_rj, out_valid, !(out_data.stop && out_data.reset_jacobian), "stop with rj")

  // No result right after reset is released
  `CHK_SAME(a_rst_empty, $rose(rst_n), !out_valid, "result valid after reset")

  // Register writes are never held off
  `CHK_SAME(a_cfg_rdy, cfg_valid, cfg_ready, "config write not taken")

endmodule

bind newton_time_step_controller ntsc_checker u_ntsc_checker (.*);

// ===== test/newton_time_step_controller_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// newton_time_step_controller_tb
// Self-checking bench for the Newton time-step controller. A driver and a
// monitor run as clocked processes. An in-bench predictor of the step
// decision tracks streak state and register settings. Every result transfer
// is checked field by field against the oldest predicted step.
// ----------------------------------------------------------------------------
module newton_time_step_controller_tb;

  localparam int LATENCY = 3;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  ntsc_pkg::in_item_t              in_data = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  ntsc_pkg::out_item_t             out_data;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ntsc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ntsc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Step reports waiting for transfer, and predicted decisions
  ntsc_pkg::in_item_t  step_reports_q[$];
  ntsc_pkg::out_item_t next_step_q[$];

  // Predictor copy of the registers and of the streak state
  ntsc_pkg::cfg_t cfg_shadow = '{ntsc_pkg::GROWTH_RST, ntsc_pkg::SHRINK_RST,
                                 ntsc_pkg::RETRY_RST, ntsc_pkg::THRESH_RST,
                                 ntsc_pkg::LIMITS_RST, ntsc_pkg::MAX_STEP_RST};
  logic [7:0] st_success = '0;
  logic [7:0] st_fail1 = '0;
  logic [7:0] st_fail2 = '0;
  logic       st_last_chance = 1'b0;
  logic       st_started = 1'b0;

  bit steady = 1'b0;  // no idling on either side while set
  int n_items = 0;
  int n_results = 0;
  int n_errors = 0;
  int n_stops = 0;
  int n_rjac = 0;
  int n_settings = 0;
  int hold_left = 0;

  newton_time_step_controller u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Q16.16 step times Q2.14 factor, truncated, exact in 48 bits
  function automatic logic [47:0] scale(input logic [31:0] s, input logic [15:0] f);
    logic [47:0] p;
    p = {16'b0, s} * {32'b0, f};
    return p >> ntsc_pkg::FRAC_FAC;
  endfunction

  function automatic logic [7:0] count_up(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  // Next step decision; updates the streak state as the block does
  function automatic ntsc_pkg::out_item_t decide_next_step(input ntsc_pkg::in_item_t it);
    ntsc_pkg::out_item_t r;
    logic [47:0] nxt;
    logic [7:0] need, lim1, lim2, grow_lo, big_lo, shrink_hi, f1, f2;
    logic [15:0] fac;
    need      = cfg_shadow.streak_limits[7:0];
    lim1      = cfg_shadow.streak_limits[15:8];
    lim2      = cfg_shadow.streak_limits[23:16];
    grow_lo   = cfg_shadow.iteration_thresholds[7:0];
    big_lo    = cfg_shadow.iteration_thresholds[15:8];
    shrink_hi = cfg_shadow.iteration_thresholds[23:16];
    nxt = {16'b0, it.step_size};
    r = '0;
    // first report after reset preloads the success streak
    if (!st_started) begin
      st_success = need;
      st_started = 1'b1;
    end
    if (it.converged) begin
      st_last_chance = 1'b0;
      if (it.iterations < grow_lo) begin
        st_success = count_up(st_success);
        if (st_success >= need) begin
          fac = (it.iterations < big_lo) ? cfg_shadow.growth_factors[31:16]
                                         : cfg_shadow.growth_factors[15:0];
          nxt = scale(it.step_size, fac);
        end
      end
      // too many iterations wins over any growth
      if (it.iterations > shrink_hi) begin
        r.reset_jacobian = 1'b1;
        st_success = '0;
        nxt = scale(it.step_size, cfg_shadow.shrink_factor);
      end
      st_fail1 = '0;
      st_fail2 = '0;
    end else begin
      f1 = count_up(st_fail1);
      f2 = st_fail2;
      if (f1 <= lim1) begin
        nxt = scale(it.step_size, cfg_shadow.retry_factors[15:0]);
      end else begin
        f2 = count_up(f2);
        if (f2 <= lim2) begin
          nxt = scale(it.step_size, cfg_shadow.retry_factors[31:16]);
        end else if (st_last_chance) begin
          // stop: step passes unclamped, state untouched
          r.new_step = it.step_size;
          r.stop = 1'b1;
          return r;
        end else begin
          nxt = scale(it.step_size, cfg_shadow.retry_factors[47:32]);
          st_last_chance = 1'b1;
        end
      end
      st_fail1 = f1;
      st_fail2 = f2;
      st_success = '0;
      r.reset_jacobian = 1'b1;
    end
    if (nxt > {16'b0, cfg_shadow.max_step}) nxt = {16'b0, cfg_shadow.max_step};
    r.new_step = nxt[31:0];
    return r;
  endfunction

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        next_step_q.push_back(decide_next_step(in_data));
        n_items++;
      end
      if (!in_valid || !in_stall) begin
        if (step_reports_q.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
          in_valid <= 1'b1;
          in_data  <= step_reports_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and checker
  always @(posedge clk) begin : monitor
    ntsc_pkg::out_item_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (next_step_q.size() == 0) begin
          $display("%0t: unexpected result transfer, actual %h", $time, out_data);
          n_errors++;
        end else begin
          want = next_step_q.pop_front();
          if (out_data.new_step !== want.new_step) begin
            $display("%0t: new_step expected %h actual %h", $time,
                     want.new_step, out_data.new_step);
            n_errors++;
          end
          if (out_data.stop !== want.stop) begin
            $display("%0t: stop expected %b actual %b", $time, want.stop, out_data.stop);
            n_errors++;
          end
          if (out_data.reset_jacobian !== want.reset_jacobian) begin
            $display("%0t: reset_jacobian expected %b actual %b", $time,
                     want.reset_jacobian, out_data.reset_jacobian);
            n_errors++;
          end
        end
        if (out_data.stop === 1'b1) n_stops++;
        if (out_data.reset_jacobian === 1'b1) n_rjac++;
        n_results++;
        // long back-pressure so the pipeline fills and stalls its input
        if (n_results == 400 || n_results == 1300) hold_left = 90;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 29);
      end
    end
  end

  task automatic write_reg(input ntsc_pkg::cfg_idx_t idx, input logic [47:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      ntsc_pkg::REG_GROWTH:   cfg_shadow.growth_factors       = val[31:0];
      ntsc_pkg::REG_SHRINK:   cfg_shadow.shrink_factor        = val[15:0];
      ntsc_pkg::REG_RETRY:    cfg_shadow.retry_factors        = val[47:0];
      ntsc_pkg::REG_THRESH:   cfg_shadow.iteration_thresholds = val[23:0];
      ntsc_pkg::REG_LIMITS:   cfg_shadow.streak_limits        = val[23:0];
      ntsc_pkg::REG_MAX_STEP: cfg_shadow.max_step             = val[31:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [31:0] growth, input logic [15:0] shrink,
                             input logic [47:0] retry, input logic [23:0] thresh,
                             input logic [23:0] limits, input logic [31:0] max_step);
    write_reg(ntsc_pkg::REG_GROWTH, {16'b0, growth});
    write_reg(ntsc_pkg::REG_SHRINK, {32'b0, shrink});
    write_reg(ntsc_pkg::REG_RETRY, retry);
    write_reg(ntsc_pkg::REG_THRESH, {24'b0, thresh});
    write_reg(ntsc_pkg::REG_LIMITS, {24'b0, limits});
    write_reg(ntsc_pkg::REG_MAX_STEP, {16'b0, max_step});
    n_settings++;
  endtask

  task automatic random_config();
    load_config($urandom, 16'($urandom), {16'($urandom), 32'($urandom)},
                {8'($urandom_range(20, 4)), 8'($urandom_range(8)), 8'($urandom_range(12))},
                {8'($urandom_range(8)), 8'($urandom_range(6)), 8'($urandom_range(8))},
                $urandom);
  endtask

  task automatic queue_item(input logic [31:0] s, input logic ok, input logic [7:0] it);
    ntsc_pkg::in_item_t t;
    t.step_size  = s;
    t.converged  = ok;
    t.iterations = it;
    step_reports_q.push_back(t);
  endtask

  // Wait until the pipeline is empty, then let it settle
  task automatic wait_drained();
    while (step_reports_q.size() != 0 || in_valid || next_step_q.size() != 0)
      @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(32'h0004_0000);
      default: return $urandom;
    endcase
  endfunction

  // mode 0: few iterations, mode 1: near a threshold, else anything
  function automatic logic [7:0] pick_iters(input int mode);
    logic [7:0] g, b, s;
    g = cfg_shadow.iteration_thresholds[7:0];
    b = cfg_shadow.iteration_thresholds[15:8];
    s = cfg_shadow.iteration_thresholds[23:16];
    if (mode == 0) begin
      if (b != 0 && $urandom_range(2) == 0) return 8'($urandom_range(b - 1, 0));
      if (g != 0) return 8'($urandom_range(g - 1, 0));
      return 8'($urandom_range(255));
    end
    if (mode == 1) begin
      case ($urandom_range(7))
        0: return g - 8'd1;
        1: return g;
        2: return b - 8'd1;
        3: return b;
        4: return s;
        5: return s + 8'd1;
        6: return 8'd0;
        default: return 8'hFF;
      endcase
    end
    return 8'($urandom_range(255));
  endfunction

  // Runs of successes and failures, with some noise in between
  task automatic queue_runs(input int n);
    int added, kind, len, i;
    added = 0;
    while (added < n) begin
      kind = $urandom_range(9);
      len  = $urandom_range(12, 1);
      for (i = 0; i < len && added < n; i++) begin
        case (kind)
          0, 1, 2, 3: queue_item(pick_step(), 1'b1, pick_iters(0));
          4, 5:       queue_item(pick_step(), 1'b1, pick_iters(1));
          6, 7, 8:    queue_item(pick_step(), 1'b0, pick_iters(2));
          default:    queue_item(pick_step(), 1'($urandom_range(1)), pick_iters(2));
        endcase
        added++;
      end
    end
  endtask

  initial begin
    int i;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: need 3 successes, two tiers of two retries each
    load_config(ntsc_pkg::GROWTH_RST, ntsc_pkg::SHRINK_RST, ntsc_pkg::RETRY_RST,
                ntsc_pkg::THRESH_RST, 24'h02_0203, ntsc_pkg::MAX_STEP_RST);
    queue_item(32'h0001_0000, 1'b1, 8'd0);   // first report preloads the streak
    queue_item(32'hFFFF_FFFF, 1'b1, 8'd2);   // big growth, clamped
    queue_item(32'h0002_0000, 1'b1, 8'd4);   // normal growth
    queue_item($urandom,      1'b1, 8'd6);   // at grow threshold: unchanged
    queue_item($urandom,      1'b1, 8'd10);  // at shrink threshold: unchanged
    queue_item(32'h0003_0000, 1'b1, 8'd11);  // shrink, Jacobian reset
    queue_item(32'hFFFF_FFFF, 1'b1, 8'hFF);
    queue_item(32'h0,         1'b1, 8'd1);   // streak rebuilding
    queue_item(32'h0001_0000, 1'b1, 8'd1);
    queue_item(32'h0001_0000, 1'b1, 8'd1);   // streak long enough again
    for (i = 0; i < 7; i++)                  // both retry tiers, final cut, stop
      queue_item($urandom, 1'b0, 8'($urandom));
    queue_item(32'h0005_0000, 1'b1, 8'd8);   // success clears the final cut
    queue_item(32'hFFFF_FFFF, 1'b0, 8'hFF);
    queue_item(32'h0,         1'b0, 8'd0);
    queue_item(32'h0,         1'b1, 8'd0);
    queue_item(32'hFFFF_FFFF, 1'b1, 8'd0);
    queue_item(32'h8000_0001, 1'b1, 8'd3);
    wait_drained();

    // Reset values, no idling anywhere
    load_config(ntsc_pkg::GROWTH_RST, ntsc_pkg::SHRINK_RST, ntsc_pkg::RETRY_RST,
                ntsc_pkg::THRESH_RST, ntsc_pkg::LIMITS_RST, ntsc_pkg::MAX_STEP_RST);
    steady = 1'b1;
    queue_runs(225);
    wait_drained();
    steady = 1'b0;

    // All zero: zero factors, every tier skipped
    load_config('0, '0, '0, '0, '0, '0);
    queue_runs(225);
    wait_drained();

    // All ones
    load_config('1, '1, '1, '1, '1, '1);
    queue_runs(225);
    wait_drained();

    random_config();
    queue_runs(225);
    wait_drained();

    // Low clamp
    load_config(ntsc_pkg::GROWTH_RST, ntsc_pkg::SHRINK_RST, ntsc_pkg::RETRY_RST,
                ntsc_pkg::THRESH_RST, ntsc_pkg::LIMITS_RST, 32'h0001_8000);
    queue_runs(225);
    wait_drained();

    // Long runs that saturate the streak counters
    load_config($urandom, 16'($urandom), {16'($urandom), 32'($urandom)},
                {8'd255, 8'd100, 8'd200}, 24'hFF_FFFF, 32'hFFFF_FFFF);
    for (i = 0; i < 260; i++) queue_item(pick_step(), 1'b0, 8'($urandom));
    for (i = 0; i < 260; i++) queue_item(pick_step(), 1'b1, 8'($urandom_range(99)));
    wait_drained();

    random_config();
    queue_runs(225);
    wait_drained();

    $display("Covered %0d step reports under %0d register settings", n_items, n_settings);
    $display("Checked %0d decisions: %0d stops, %0d Jacobian resets",
             n_results, n_stops, n_rjac);
    if (n_errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #400000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
